FILE: hdl/lsr_pkg.sv
package lsr_pkg;

  // Sizes of the window and of the replacement store.
  localparam int MaxPattern = 16;
  localparam int MaxRepl    = 16;
  localparam int ByteW      = 8;
  localparam int CntW       = 5;
  localparam int IdxW       = 4;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int HalfBytes  = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LEN  = 3'd0,
    REG_PATTERN_LOW  = 3'd1,
    REG_PATTERN_HIGH = 3'd2,
    REG_REPL_LEN     = 3'd3,
    REG_REPL_LOW     = 3'd4,
    REG_REPL_HIGH    = 3'd5
  } cfg_reg_e;

  // One byte of the stream together with its end-of-stream mark.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } item_t;

  // Configuration as seen by the engine, lengths already clamped.
  typedef struct packed {
    logic [CntW-1:0]             plen;
    logic [CntW-1:0]             rlen;
    logic [MaxPattern*ByteW-1:0] pattern;
    logic [MaxRepl*ByteW-1:0]    repl;
  } cfg_t;

  // Engine status reported to the top level.
  typedef struct packed {
    logic            busy;
    logic            repl;
    logic [CntW-1:0] cnt;
  } eng_status_t;

endpackage

FILE: hdl/lsr_queue.sv
module lsr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lsr_pkg::item_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lsr_pkg::item_t out_item_o
);

  lsr_pkg::item_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     fill_q;
  logic           push;
  logic           pop;

  // Handshake on both sides of the two-entry queue.
  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

FILE: hdl/lsr_engine.sv
module lsr_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsr_pkg::cfg_t       cfg_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  lsr_pkg::item_t      item_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output lsr_pkg::item_t      m_item_o,
  output lsr_pkg::eng_status_t status_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_REPL
  } state_e;

  state_e                          state_q;
  logic [lsr_pkg::CntW-1:0]        cnt_q;
  logic [lsr_pkg::CntW-1:0]        tgt_q;
  logic [lsr_pkg::IdxW-1:0]        idx_q;
  logic [lsr_pkg::ByteW-1:0]       win_q [lsr_pkg::MaxPattern];
  logic                            out_valid_q;
  lsr_pkg::item_t                  out_item_q;

  logic                            slot_free;
  logic                            take;
  logic [lsr_pkg::IdxW-1:0]        wr_idx;
  logic [lsr_pkg::CntW-1:0]        new_cnt;
  logic [lsr_pkg::CntW-1:0]        new_tgt;
  logic [lsr_pkg::MaxPattern-1:0]  hit;
  logic [lsr_pkg::ByteW-1:0]       entry [lsr_pkg::MaxPattern];
  logic                            match;
  logic                            pop_last;
  logic                            repl_last;
  logic [lsr_pkg::ByteW-1:0]       repl_byte;

  assign slot_free    = !out_valid_q || m_ready_i;
  assign item_ready_o = (state_q == ST_IDLE);
  assign take         = item_ready_o && item_valid_i;

  // A full window keeps its last slot for the incoming byte.
  assign wr_idx  = (cnt_q >= lsr_pkg::CntW'(lsr_pkg::MaxPattern))
                   ? lsr_pkg::IdxW'(lsr_pkg::MaxPattern - 1) : cnt_q[lsr_pkg::IdxW-1:0];
  assign new_cnt = {1'b0, wr_idx} + lsr_pkg::CntW'(1);

  // Compare the window, with the incoming byte merged in, against the pattern.
  always_comb begin
    for (int i = 0; i < lsr_pkg::MaxPattern; i++) begin
      entry[i] = (lsr_pkg::IdxW'(i) == wr_idx) ? item_i.data : win_q[i];
      hit[i]   = (lsr_pkg::CntW'(i) >= cfg_i.plen)
                 || (entry[i] == cfg_i.pattern[i*lsr_pkg::ByteW +: lsr_pkg::ByteW]);
    end
  end
  assign match = (&hit) && (new_cnt == cfg_i.plen);

  // Drain target: empty on the last byte, one short of the pattern once the window reaches it, else the new level.
  always_comb begin
    if (item_i.last) begin
      new_tgt = '0;
    end else if (new_cnt >= cfg_i.plen) begin
      new_tgt = cfg_i.plen - lsr_pkg::CntW'(1);
    end else begin
      new_tgt = new_cnt;
    end
  end

  assign pop_last  = ((cnt_q - lsr_pkg::CntW'(1)) == tgt_q);
  assign repl_last = (({1'b0, idx_q} + lsr_pkg::CntW'(1)) == cfg_i.rlen);
  assign repl_byte = cfg_i.repl[idx_q*lsr_pkg::ByteW +: lsr_pkg::ByteW];

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tgt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            if (match) begin
              cnt_q <= '0;
              idx_q <= '0;
              if (cfg_i.rlen != '0) begin
                state_q <= ST_REPL;
              end
            end else begin
              cnt_q <= new_cnt;
              tgt_q <= new_tgt;
              if (new_cnt != new_tgt) begin
                state_q <= ST_POP;
              end
            end
          end
        end
        ST_POP: begin
          if (slot_free) begin
            out_valid_q     <= 1'b1;
            out_item_q.data <= win_q[0];
            out_item_q.last <= pop_last;
            cnt_q           <= cnt_q - lsr_pkg::CntW'(1);
            if (pop_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_REPL: begin
          if (slot_free) begin
            out_valid_q     <= 1'b1;
            out_item_q.data <= repl_byte;
            out_item_q.last <= repl_last;
            idx_q           <= idx_q + lsr_pkg::IdxW'(1);
            if (repl_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Window storage: append at the fill level, shift down on each emitted window byte.
  always_ff @(posedge clk_i) begin
    if (take) begin
      win_q[wr_idx] <= item_i.data;
    end else if ((state_q == ST_POP) && slot_free) begin
      for (int i = 0; i < lsr_pkg::MaxPattern - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end
  end

  assign m_valid_o       = out_valid_q;
  assign m_item_o        = out_item_q;
  assign status_o.busy   = (state_q != ST_IDLE);
  assign status_o.repl   = (state_q == ST_REPL);
  assign status_o.cnt    = cnt_q;

endmodule

FILE: hdl/literal_string_replace_stream.sv
// Streaming literal string replacement.
// Bytes enter on the s_axis channel (tdata carries the byte, tlast marks the
// end of a stream) and the substituted bytes leave on m_axis; m_axis_tlast is
// set on the final output byte that one input byte gives rise to.
// Pattern and replacement are set through the cfg write port while the block
// is idle: index 0 pattern length, 1 and 2 pattern bytes, 3 replacement
// length, 4 and 5 replacement bytes, byte 0 in the low bits.
// Input bytes pass a two-entry queue into the matching engine. The engine
// takes one byte per cycle while that byte produces no output; a byte that
// produces k output bytes keeps the engine busy until all k are loaded into
// the single output register, one byte per cycle while the receiver accepts.
// An input byte is queued and taken in idle before its output is registered.
// A stalled receiver holds the output register, which stops the engine; the
// queue keeps accepting until its two entries are full.
// Reset empties the window and the queue, sets the pattern length to one and
// clears the other registers but for the window and queue byte storage.
module literal_string_replace_stream (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // in_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // out_byte
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [lsr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lsr_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam int HalfW = lsr_pkg::HalfBytes * lsr_pkg::ByteW;

  logic [lsr_pkg::CntW-1:0]  plen_q;
  logic [lsr_pkg::CntW-1:0]  rlen_q;
  logic [HalfW-1:0]          pat_lo_q;
  logic [HalfW-1:0]          pat_hi_q;
  logic [HalfW-1:0]          repl_lo_q;
  logic [HalfW-1:0]          repl_hi_q;

  lsr_pkg::cfg_t             cfg;
  lsr_pkg::item_t            in_item;
  lsr_pkg::item_t            q_item;
  lsr_pkg::item_t            out_item;
  lsr_pkg::eng_status_t      eng_status;
  logic                      q_valid;
  logic                      q_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q    <= lsr_pkg::CntW'(1);
      rlen_q    <= '0;
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      repl_lo_q <= '0;
      repl_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsr_pkg::REG_PATTERN_LEN:  plen_q    <= cfg_wdata_i[lsr_pkg::CntW-1:0];
        lsr_pkg::REG_PATTERN_LOW:  pat_lo_q  <= cfg_wdata_i;
        lsr_pkg::REG_PATTERN_HIGH: pat_hi_q  <= cfg_wdata_i;
        lsr_pkg::REG_REPL_LEN:     rlen_q    <= cfg_wdata_i[lsr_pkg::CntW-1:0];
        lsr_pkg::REG_REPL_LOW:     repl_lo_q <= cfg_wdata_i;
        lsr_pkg::REG_REPL_HIGH:    repl_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the lengths into their usable ranges.
  always_comb begin
    if (plen_q == '0) begin
      cfg.plen = lsr_pkg::CntW'(1);
    end else if (plen_q > lsr_pkg::CntW'(lsr_pkg::MaxPattern)) begin
      cfg.plen = lsr_pkg::CntW'(lsr_pkg::MaxPattern);
    end else begin
      cfg.plen = plen_q;
    end
    if (rlen_q > lsr_pkg::CntW'(lsr_pkg::MaxRepl)) begin
      cfg.rlen = lsr_pkg::CntW'(lsr_pkg::MaxRepl);
    end else begin
      cfg.rlen = rlen_q;
    end
    cfg.pattern = {pat_hi_q, pat_lo_q};
    cfg.repl    = {repl_hi_q, repl_lo_q};
  end

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  // Front: input queue.
  lsr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  // Back: window, matcher and output register.
  lsr_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_item_o     (out_item),
    .status_o     (eng_status)
  );

  assign m_axis_tdata = out_item.data;
  assign m_axis_tlast = out_item.last;

  // The window never holds more bytes than the pattern store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_status.cnt <= lsr_pkg::CntW'(lsr_pkg::MaxPattern))
    else $error("window count above its maximum");

  // A match always clears the window before the replacement is sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_status.repl |-> (eng_status.cnt == '0))
    else $error("window not cleared during replacement");

  // A busy engine with an empty output register loads a byte at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_status.busy && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("engine busy but output register left empty");

endmodule

FILE: dv/literal_string_replace_stream_tb.sv
module literal_string_replace_stream_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata = '0;   // in_byte
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [7:0]                  m_axis_tdata;        // out_byte
  logic                        m_axis_tlast;
  logic                        cfg_we_i = 1'b0;
  logic [lsr_pkg::CfgIdxW-1:0] cfg_idx_i = lsr_pkg::REG_PATTERN_LEN;
  logic [lsr_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  literal_string_replace_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Text bytes waiting to be sent, and substituted bytes still to come.
  lsr_pkg::item_t pending_text_q[$];
  lsr_pkg::item_t expected_out_q[$];
  lsr_pkg::item_t step_out_q[$];

  int err_cnt;
  int text_offered;
  int text_accepted;
  int text_queued;
  int src_gap;
  int snk_gap;
  int src_pct;
  int snk_pct;
  int long_stall_reqs;
  int long_stall_seen;
  lsr_pkg::item_t drv_item;

  // Our own copy of the configuration and of the unemitted window.
  logic [4:0]  pat_len_q = 5'd1;
  logic [63:0] pat_lo_q = '0;
  logic [63:0] pat_hi_q = '0;
  logic [4:0]  repl_len_q = '0;
  logic [63:0] repl_lo_q = '0;
  logic [63:0] repl_hi_q = '0;
  logic [7:0]  win_q [lsr_pkg::MaxPattern];
  int          win_cnt;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Backstop against a hung handshake.
  initial begin
    #(20 * 2000000);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_error(input string msg);
    err_cnt++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [7:0] cfg_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input int i);
    return (i < lsr_pkg::HalfBytes) ? lo[8*i +: 8] : hi[8*(i-lsr_pkg::HalfBytes) +: 8];
  endfunction

  function automatic int clamp_plen(input logic [4:0] n);
    if (n == 0) return 1;
    if (n > lsr_pkg::MaxPattern) return lsr_pkg::MaxPattern;
    return int'(n);
  endfunction

  // Emit the oldest window byte and shift the rest down.
  task automatic emit_oldest();
    lsr_pkg::item_t r;
    r.data = win_q[0];
    r.last = 1'b0;
    step_out_q.push_back(r);
    for (int k = 0; k < win_cnt - 1; k++) win_q[k] = win_q[k+1];
    win_cnt--;
  endtask

  // Work out the bytes that one accepted text byte gives rise to.
  task automatic predict_substitution(input logic [7:0] b, input logic lst);
    int             plen;
    int             rlen;
    bit             hit;
    lsr_pkg::item_t r;
    plen = clamp_plen(pat_len_q);
    rlen = (int'(repl_len_q) > lsr_pkg::MaxRepl) ? lsr_pkg::MaxRepl : int'(repl_len_q);
    step_out_q.delete();
    if (win_cnt >= lsr_pkg::MaxPattern) win_cnt = lsr_pkg::MaxPattern - 1;
    win_q[win_cnt] = b;
    win_cnt++;
    if (win_cnt > plen) begin
      // The pattern was shortened: no match test, just drain down.
      while (win_cnt + 1 > plen && win_cnt > 0) emit_oldest();
    end else if (win_cnt == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (win_q[i] != cfg_byte(pat_lo_q, pat_hi_q, i)) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < rlen; i++) begin
          r.data = cfg_byte(repl_lo_q, repl_hi_q, i);
          r.last = 1'b0;
          step_out_q.push_back(r);
        end
        win_cnt = 0;
      end else begin
        emit_oldest();
      end
    end
    if (lst) begin
      while (win_cnt > 0) emit_oldest();
    end
    if (step_out_q.size() > 0) step_out_q[step_out_q.size()-1].last = 1'b1;
    foreach (step_out_q[k]) expected_out_q.push_back(step_out_q[k]);
  endtask

  // Input side: offer queued text bytes, with random bursts of idling.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || text_accepted == text_offered) begin
        if (src_gap == 0 && $urandom_range(99, 0) < src_pct) src_gap = $urandom_range(18, 1);
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_text_q.size() > 0) begin
          drv_item = pending_text_q.pop_front();
          s_axis_tdata  <= drv_item.data;
          s_axis_tlast  <= drv_item.last;
          s_axis_tvalid <= 1'b1;
          text_offered++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_stall_reqs != long_stall_seen) begin
        long_stall_seen++;
        snk_gap = 400;
      end else if (snk_gap == 0 && $urandom_range(99, 0) < snk_pct) begin
        snk_gap = $urandom_range(18, 1);
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check each output transfer, then predict from each input transfer.
  always @(posedge clk_i) begin
    lsr_pkg::item_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out_q.size() == 0) begin
          report_error($sformatf("unexpected output byte %02h last %0b",
                                 m_axis_tdata, m_axis_tlast));
        end else begin
          want = expected_out_q.pop_front();
          if (m_axis_tdata !== want.data)
            report_error($sformatf("out_byte %02h, expected %02h", m_axis_tdata, want.data));
          if (m_axis_tlast !== want.last)
            report_error($sformatf("out_last %0b, expected %0b on byte %02h",
                                   m_axis_tlast, want.last, want.data));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        text_accepted++;
        predict_substitution(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  task automatic cfg_write(input lsr_pkg::cfg_reg_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lsr_pkg::REG_PATTERN_LEN:  pat_len_q = val[4:0];
      lsr_pkg::REG_PATTERN_LOW:  pat_lo_q = val;
      lsr_pkg::REG_PATTERN_HIGH: pat_hi_q = val;
      lsr_pkg::REG_REPL_LEN:     repl_len_q = val[4:0];
      lsr_pkg::REG_REPL_LOW:     repl_lo_q = val;
      lsr_pkg::REG_REPL_HIGH:    repl_hi_q = val;
      default: ;
    endcase
  endtask

  task automatic load_cfg(input logic [63:0] plen, input logic [63:0] plo,
                          input logic [63:0] phi, input logic [63:0] rlen,
                          input logic [63:0] rlo, input logic [63:0] rhi);
    cfg_write(lsr_pkg::REG_PATTERN_LEN, plen);
    cfg_write(lsr_pkg::REG_PATTERN_LOW, plo);
    cfg_write(lsr_pkg::REG_PATTERN_HIGH, phi);
    cfg_write(lsr_pkg::REG_REPL_LEN, rlen);
    cfg_write(lsr_pkg::REG_REPL_LOW, rlo);
    cfg_write(lsr_pkg::REG_REPL_HIGH, rhi);
  endtask

  task automatic queue_text(input logic [7:0] b, input logic lst);
    lsr_pkg::item_t it;
    it.data = b;
    it.last = lst;
    pending_text_q.push_back(it);
    text_queued++;
  endtask

  // Wait until every byte is sent and every expected byte has come back,
  // then allow for bytes that produce nothing but are still in flight.
  task automatic wait_idle();
    while (pending_text_q.size() > 0 || text_accepted != text_offered
           || expected_out_q.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // One random setting followed by text that is mostly built from the
  // pattern, with broken copies and noise mixed in.
  task automatic random_phase(input int n_items);
    logic [7:0]  alpha [4];
    logic [4:0]  plen_w;
    logic [4:0]  rlen_w;
    logic [63:0] plo;
    logic [63:0] phi;
    logic [63:0] plen_v;
    logic [63:0] rlen_v;
    int          eff;
    int          cnt;
    int          r;
    int          part;
    foreach (alpha[k]) alpha[k] = 8'($urandom_range(255, 0));
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: plen_w = 5'($urandom_range(3, 1));
      6, 7:             plen_w = 5'($urandom_range(16, 4));
      8:                plen_w = 5'd16;
      default:          plen_w = ($urandom_range(1, 0) != 0) ? 5'd0
                                                              : 5'($urandom_range(31, 17));
    endcase
    case ($urandom_range(9, 0))
      0, 1:    rlen_w = 5'd0;
      2, 3, 4: rlen_w = 5'($urandom_range(3, 1));
      5, 6:    rlen_w = 5'($urandom_range(15, 4));
      7:       rlen_w = 5'd16;
      default: rlen_w = 5'($urandom_range(31, 17));
    endcase
    case ($urandom_range(9, 0))
      0: begin plo = '0; phi = '0; alpha[0] = 8'h00; end
      1: begin plo = '1; phi = '1; alpha[0] = 8'hFF; end
      2: begin plo = {$urandom, $urandom}; phi = {$urandom, $urandom}; end
      default: begin
        for (int k = 0; k < 8; k++) begin
          plo[8*k +: 8] = alpha[$urandom_range(3, 0)];
          phi[8*k +: 8] = alpha[$urandom_range(3, 0)];
        end
      end
    endcase
    // Upper bits of the length registers are ignored by the block.
    plen_v = {59'd0, plen_w};
    rlen_v = {59'd0, rlen_w};
    if ($urandom_range(4, 0) == 0) plen_v[63:5] = 59'({$urandom, $urandom});
    if ($urandom_range(4, 0) == 0) rlen_v[63:5] = 59'({$urandom, $urandom});
    load_cfg(plen_v, plo, phi, rlen_v, {$urandom, $urandom}, {$urandom, $urandom});
    eff = clamp_plen(plen_w);
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(99, 0);
      if (r < 40) begin
        for (int k = 0; k < eff; k++) queue_text(cfg_byte(plo, phi, k), 1'b0);
        cnt += eff;
      end else if (r < 55 && eff > 1) begin
        part = $urandom_range(eff - 1, 1);
        for (int k = 0; k < part; k++) queue_text(cfg_byte(plo, phi, k), 1'b0);
        queue_text(alpha[$urandom_range(3, 0)], 1'b0);
        cnt += part + 1;
      end else if (r < 80) begin
        queue_text(alpha[$urandom_range(3, 0)], $urandom_range(15, 0) == 0);
        cnt++;
      end else begin
        queue_text(8'($urandom_range(255, 0)), $urandom_range(15, 0) == 0);
        cnt++;
      end
    end
    if ($urandom_range(1, 0) != 0) pending_text_q[pending_text_q.size()-1].last = 1'b1;
  endtask

  initial begin
    int phase_no;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: a single zero byte is deleted, other bytes pass.
    // Covers a match with no replacement and a last byte that leaves nothing.
    src_pct = 0;
    snk_pct = 0;
    queue_text(8'h00, 1'b0);
    queue_text(8'hFF, 1'b0);
    queue_text(8'h00, 1'b1);
    queue_text(8'h7F, 1'b1);
    wait_idle();

    // Pattern length zero behaves as one.
    load_cfg(64'd0, 64'h0000_0000_0000_00AA, 64'd0, 64'd3,
             64'h0000_0000_0003_C35A, 64'd0);
    queue_text(8'hAA, 1'b0);
    queue_text(8'h80, 1'b1);
    wait_idle();

    // Longest pattern and longest replacement: one byte gives sixteen.
    snk_pct = 10;
    load_cfg(64'd16, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd16,
             64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001);
    for (int k = 0; k < 16; k++)
      queue_text(cfg_byte(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, k), 1'b0);
    wait_idle();

    // Leave three bytes in the window, then shorten the pattern below that.
    queue_text(8'h11, 1'b0);
    queue_text(8'h22, 1'b0);
    queue_text(8'h33, 1'b0);
    wait_idle();
    cfg_write(lsr_pkg::REG_PATTERN_LEN, 64'd2);
    cfg_write(lsr_pkg::REG_REPL_LEN, 64'd31);
    queue_text(8'h44, 1'b1);
    wait_idle();

    // Random settings and text until the item budget is spent.
    phase_no = 0;
    while (text_queued < 410) begin
      if (text_queued > 350) begin
        src_pct = 0;
        snk_pct = 0;
      end else begin
        case ($urandom_range(3, 0))
          0: src_pct = 0;
          1: src_pct = 3;
          2: src_pct = 8;
          default: src_pct = 20;
        endcase
        case ($urandom_range(3, 0))
          0: snk_pct = 0;
          1: snk_pct = 3;
          2: snk_pct = 8;
          default: snk_pct = 20;
        endcase
      end
      random_phase($urandom_range(40, 15));
      // Hold the receiver off while the sender keeps offering.
      if (phase_no == 2) long_stall_reqs++;
      wait_idle();
      phase_no++;
    end

    for (int c = 0; c < 200000 && expected_out_q.size() > 0; c++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_out_q.size() != 0)
      report_error($sformatf("%0d expected bytes never arrived", expected_out_q.size()));
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
